>>> rtl/pdfv_pkg.sv
// shared types, constants and the arctangent table for the pd follow velocity controller
package pdfv_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;

  localparam int CW  = 54;
  localparam int ZW  = 35;
  localparam int MAW = 46;
  localparam int MBW = 25;
  localparam int MPW = MAW + MBW;

  localparam logic [2:0] REG_KP_LIN      = 3'd0;
  localparam logic [2:0] REG_KD_LIN      = 3'd1;
  localparam logic [2:0] REG_KP_ANG      = 3'd2;
  localparam logic [2:0] REG_KD_ANG      = 3'd3;
  localparam logic [2:0] REG_GOAL_TOL    = 3'd4;
  localparam logic [2:0] REG_MAX_LIN_VEL = 3'd5;
  localparam logic [2:0] REG_MAX_ANG_VEL = 3'd6;

  localparam logic signed [ZW-1:0] PI_Q30        = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30   = 35'sd1686629713;
  localparam logic signed [ZW-1:0] INV_GAIN_Q30  = 35'sd652032874;
  localparam logic [23:0]          INV_GAIN_Q24  = 24'd10188014;
  localparam logic signed [36:0]   PI_E30        = 37'sd3373259426;
  localparam logic signed [36:0]   TWO_PI_E30    = 37'sd6746518852;
  localparam logic signed [17:0]   PI_Q13        = 18'sd25736;
  localparam logic signed [17:0]   TWO_PI_Q13    = 18'sd51472;

  typedef struct packed {
    logic start;
    logic rotate;
  } cordic_cmd_t;

  function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:    r = 35'sd843314857;
      5'd1:    r = 35'sd497837829;
      5'd2:    r = 35'sd263043837;
      5'd3:    r = 35'sd133525159;
      5'd4:    r = 35'sd67021687;
      5'd5:    r = 35'sd33543516;
      5'd6:    r = 35'sd16775851;
      5'd7:    r = 35'sd8388437;
      5'd8:    r = 35'sd4194283;
      5'd9:    r = 35'sd2097149;
      5'd10:   r = 35'sd1048576;
      default: r = $signed((ZW'(1) << 30) >> i);
    endcase
    return r;
  endfunction

endpackage

>>> rtl/pdfv_ifs.sv
// valid/ready channel interfaces for pose input and velocity result
interface pdfv_in_if;
  logic               valid;
  logic               ready;
  logic               poses_ready;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] robot_x;
  logic signed [31:0] robot_y;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source(output valid, poses_ready, target_x, target_y, robot_x, robot_y,
                 quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, poses_ready, target_x, target_y, robot_x, robot_y,
               quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface pdfv_out_if;
  logic               valid;
  logic               ready;
  logic [14:0]        linear_vel;
  logic signed [15:0] angular_vel;
  logic               goal_reached;

  modport source(output valid, linear_vel, angular_vel, goal_reached, input ready);
  modport sink(input valid, linear_vel, angular_vel, goal_reached, output ready);
endinterface

>>> rtl/pdfv_cordic.sv
// iterative cordic unit, vectoring or rotation, one micro-rotation per cycle
module pdfv_cordic import pdfv_pkg::*; #(
  parameter int ITERS = CORDIC_ITERATIONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cordic_cmd_t          cmd,
  input  logic signed [CW-1:0] x0,
  input  logic signed [CW-1:0] y0,
  input  logic signed [ZW-1:0] z0,
  output logic                 done,
  output logic signed [CW-1:0] x_out,
  output logic signed [ZW-1:0] z_out
);

  localparam int N  = (ITERS > 32) ? 32 : ITERS;
  localparam int IW = $clog2(N);

  logic                 busy_r;
  logic                 done_r;
  logic                 rot_r;
  logic [IW-1:0]        cnt_r;
  logic signed [CW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic [4:0]           sh;
  logic signed [CW-1:0] xs, ys;
  logic signed [ZW-1:0] at;

  assign sh = 5'(cnt_r);
  assign xs = x_r >>> sh;
  assign ys = y_r >>> sh;
  assign at = atan_step(sh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == IW'(N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rot_r <= cmd.rotate;
      if (cmd.rotate) begin
        x_r <= x0;
        y_r <= y0;
        z_r <= z0;
      end else if (x0 < 0) begin
        x_r <= -x0;
        y_r <= -y0;
        z_r <= (y0 >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        x_r <= x0;
        y_r <= y0;
        z_r <= '0;
      end
    end else if (busy_r) begin
      if (rot_r) begin
        if (z_r >= 0) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end
      end else begin
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end
      end
    end
  end

  assign done  = done_r;
  assign x_out = x_r;
  assign z_out = z_r;

endmodule

>>> rtl/pdfv_mul.sv
// shared signed multiplier with registered product
module pdfv_mul import pdfv_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [MAW-1:0] a,
  input  logic signed [MBW-1:0] b,
  output logic signed [MPW-1:0] p
);

  logic signed [MPW-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

  assign p = p_r;

endmodule

>>> rtl/pd_follow_velocity_controller_unit.sv
// pd go-to-goal velocity controller top level with sequencer and register file
// One item is taken at a time. A tick with poses_ready low is dropped. Otherwise
// the sequencer runs the one cordic unit up to three times (distance/heading, yaw, cos of the
// heading error), and the one multiplier for the distance scale, quaternion products, both pd
// laws and the cos scaling of the linear command; the cos pass is skipped when the heading
// error is at least a quarter turn, a goal-reached item skips the yaw and cos passes, and
// the last step waits while an earlier result is still held. The result register lets the
// next item start while a result waits.
module pd_follow_velocity_controller_unit import pdfv_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pdfv_in_if.sink     in_bus,
  pdfv_out_if.source  out_bus,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [30:0] cfg_data
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DIFF  = 5'd1;
  localparam logic [4:0] S_VEC1  = 5'd2;
  localparam logic [4:0] S_VEC1W = 5'd3;
  localparam logic [4:0] S_MAG   = 5'd4;
  localparam logic [4:0] S_DIST  = 5'd5;
  localparam logic [4:0] S_GOAL  = 5'd6;
  localparam logic [4:0] S_Q1    = 5'd7;
  localparam logic [4:0] S_Q2    = 5'd8;
  localparam logic [4:0] S_Q3    = 5'd9;
  localparam logic [4:0] S_Q4    = 5'd10;
  localparam logic [4:0] S_VEC2  = 5'd11;
  localparam logic [4:0] S_VEC2W = 5'd12;
  localparam logic [4:0] S_ERR   = 5'd13;
  localparam logic [4:0] S_ADE   = 5'd14;
  localparam logic [4:0] S_ALIGN = 5'd15;
  localparam logic [4:0] S_ROTW  = 5'd16;
  localparam logic [4:0] S_PD0   = 5'd17;
  localparam logic [4:0] S_PD1   = 5'd18;
  localparam logic [4:0] S_PD2   = 5'd19;
  localparam logic [4:0] S_PD3   = 5'd20;
  localparam logic [4:0] S_PD4   = 5'd21;
  localparam logic [4:0] S_PD5   = 5'd22;

  // configuration
  logic [15:0] kp_lin_r, kd_lin_r, kp_ang_r, kd_ang_r;
  logic [30:0] goal_tol_r;
  logic [14:0] max_lin_r, max_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_lin_r   <= 16'd256;
      kd_lin_r   <= 16'd2560;
      kp_ang_r   <= 16'd640;
      kd_ang_r   <= 16'd3840;
      goal_tol_r <= 31'd9830;
      max_lin_r  <= 15'd4096;
      max_ang_r  <= 15'd8192;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_KP_LIN:      kp_lin_r   <= cfg_data[15:0];
        REG_KD_LIN:      kd_lin_r   <= cfg_data[15:0];
        REG_KP_ANG:      kp_ang_r   <= cfg_data[15:0];
        REG_KD_ANG:      kd_ang_r   <= cfg_data[15:0];
        REG_GOAL_TOL:    goal_tol_r <= cfg_data;
        REG_MAX_LIN_VEL: max_lin_r  <= cfg_data[14:0];
        REG_MAX_ANG_VEL: max_ang_r  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic [4:0]           state_r;
  logic                 out_valid_r;
  logic [14:0]          out_lin_r;
  logic signed [15:0]   out_ang_r;
  logic                 out_goal_r;
  logic [31:0]          prev_dist_r;
  logic signed [15:0]   prev_ang_r;

  logic signed [31:0]   tx_r, ty_r, rx_r, ry_r;
  logic signed [15:0]   qw_r, qx_r, qy_r, qz_r;
  logic signed [32:0]   dx_r, dy_r;
  logic signed [ZW-1:0] desired_r, yaw_r;
  logic [CW-17:0]       xs_r;
  logic [31:0]          dist_r;
  logic signed [49:0]   acc_r;
  logic signed [32:0]   sum1_r, sum2_r;
  logic signed [15:0]   ae_r, ade_r;
  logic [15:0]          align_r;
  logic signed [50:0]   vpd_r;
  logic signed [15:0]   wq_r;

  // shared units
  cordic_cmd_t           cmd;
  logic signed [CW-1:0]  c_x0, c_y0;
  logic signed [ZW-1:0]  c_z0;
  logic                  c_done;
  logic signed [CW-1:0]  c_x;
  logic signed [ZW-1:0]  c_z;
  logic                  mul_en;
  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [MPW-1:0] mul_p;

  pdfv_cordic #(.ITERS(CORDIC_ITERATIONS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .x0(c_x0), .y0(c_y0), .z0(c_z0),
    .done(c_done), .x_out(c_x), .z_out(c_z)
  );

  pdfv_mul u_mul (.clk(clk), .en(mul_en), .a(mul_a), .b(mul_b), .p(mul_p));

  // datapath helpers
  logic                 slot_free;
  logic                 out_load;
  logic signed [35:0]   yarg;
  logic signed [CW-1:0] xg_rnd;
  logic [MPW-1:0]       mag_sum;
  logic signed [36:0]   e30, e1, e2, ae_full;
  logic signed [17:0]   dd, dd1, dd2;
  logic signed [ZW-1:0] zang, zabs;
  logic signed [CW-1:0] al_full;
  logic signed [32:0]   d_lin;
  logic [43:0]          vpd_clip;
  logic signed [33:0]   w_sum;
  logic signed [34:0]   w_rnd;
  logic signed [34:0]   max_ang_s;
  logic [MPW-1:0]       v_sum;
  logic [31:0]          v32;
  logic [14:0]          v_fin;

  assign slot_free = !out_valid_r || out_bus.ready;
  assign out_load  = slot_free &&
                     ((state_r == S_GOAL && dist_r < {1'b0, goal_tol_r}) ||
                      (state_r == S_PD5));
  assign yarg      = (36'sd1 <<< 28) - (36'(sum2_r) <<< 1);
  assign xg_rnd    = c_x + CW'(32768);
  assign mag_sum   = $unsigned(mul_p) + (MPW'(1) << 23);

  assign e30     = 37'(desired_r) - 37'(yaw_r);
  assign e1      = (e30 > PI_E30) ? e30 - TWO_PI_E30 : e30;
  assign e2      = (e1 < -PI_E30) ? e1 + TWO_PI_E30 : e1;
  assign ae_full = (e2 + 37'sd65536) >>> 17;

  assign dd  = 18'(ae_r) - 18'(prev_ang_r);
  assign dd1 = (dd > PI_Q13) ? dd - TWO_PI_Q13 : dd;
  assign dd2 = (dd1 < -PI_Q13) ? dd1 + TWO_PI_Q13 : dd1;

  assign zang    = ZW'(ae_r) <<< 17;
  assign zabs    = (zang < 0) ? -zang : zang;
  assign al_full = (c_x + CW'(16384)) >>> 15;

  assign d_lin    = $signed({1'b0, dist_r}) - $signed({1'b0, prev_dist_r});
  assign vpd_clip = (vpd_r > (51'sd1 <<< 43)) ? (44'd1 << 43) : vpd_r[43:0];

  assign w_sum     = 34'(acc_r + mul_p);
  assign w_rnd     = (35'(w_sum) + 35'sd256) >>> 9;
  assign max_ang_s = $signed({20'd0, max_ang_r});

  assign v_sum = $unsigned(mul_p) + (MPW'(1) << 26);
  assign v32   = v_sum[58:27];
  assign v_fin = (vpd_r <= 0) ? 15'd0 :
                 (v32 > {17'd0, max_lin_r}) ? max_lin_r : v32[14:0];

  always_comb begin
    cmd    = '0;
    c_x0   = '0;
    c_y0   = '0;
    c_z0   = '0;
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_VEC1: begin
        cmd.start = !(dx_r == 0 && dy_r == 0);
        c_x0      = CW'(dx_r) <<< 16;
        c_y0      = CW'(dy_r) <<< 16;
      end
      S_MAG: begin
        mul_en = 1'b1;
        mul_a  = MAW'(xs_r);
        mul_b  = MBW'(INV_GAIN_Q24);
      end
      S_GOAL: begin
        mul_en = 1'b1;
        mul_a  = MAW'(qw_r);
        mul_b  = MBW'(qz_r);
      end
      S_Q1: begin
        mul_en = 1'b1;
        mul_a  = MAW'(qx_r);
        mul_b  = MBW'(qy_r);
      end
      S_Q2: begin
        mul_en = 1'b1;
        mul_a  = MAW'(qy_r);
        mul_b  = MBW'(qy_r);
      end
      S_Q3: begin
        mul_en = 1'b1;
        mul_a  = MAW'(qz_r);
        mul_b  = MBW'(qz_r);
      end
      S_VEC2: begin
        cmd.start = 1'b1;
        c_x0      = CW'(sum1_r) <<< 17;
        c_y0      = CW'(yarg) <<< 16;
      end
      S_ALIGN: begin
        cmd.start  = (zabs < HALF_PI_Q30);
        cmd.rotate = 1'b1;
        c_x0       = CW'(INV_GAIN_Q30);
        c_z0       = zang;
      end
      S_PD0: begin
        mul_en = 1'b1;
        mul_a  = MAW'(dist_r);
        mul_b  = MBW'(kp_lin_r);
      end
      S_PD1: begin
        mul_en = 1'b1;
        mul_a  = MAW'(d_lin);
        mul_b  = MBW'(kd_lin_r);
      end
      S_PD2: begin
        mul_en = 1'b1;
        mul_a  = MAW'(ae_r);
        mul_b  = MBW'(kp_ang_r);
      end
      S_PD3: begin
        mul_en = 1'b1;
        mul_a  = MAW'(ade_r);
        mul_b  = MBW'(kd_ang_r);
      end
      S_PD4: begin
        mul_en = 1'b1;
        mul_a  = MAW'(vpd_clip);
        mul_b  = MBW'(align_r);
      end
      default: ;
    endcase
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      prev_dist_r <= '0;
      prev_ang_r  <= '0;
    end else begin
      if (out_valid_r && out_bus.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_bus.valid && in_bus.poses_ready) begin
            state_r <= S_DIFF;
          end
        end
        S_DIFF:  state_r <= S_VEC1;
        S_VEC1:  state_r <= (dx_r == 0 && dy_r == 0) ? S_GOAL : S_VEC1W;
        S_VEC1W: begin
          if (c_done) begin
            state_r <= S_MAG;
          end
        end
        S_MAG:  state_r <= S_DIST;
        S_DIST: state_r <= S_GOAL;
        S_GOAL: begin
          if (dist_r < {1'b0, goal_tol_r}) begin
            if (slot_free) begin
              out_valid_r <= 1'b1;
              prev_dist_r <= '0;
              prev_ang_r  <= '0;
              state_r     <= S_IDLE;
            end
          end else begin
            state_r <= S_Q1;
          end
        end
        S_Q1:    state_r <= S_Q2;
        S_Q2:    state_r <= S_Q3;
        S_Q3:    state_r <= S_Q4;
        S_Q4:    state_r <= S_VEC2;
        S_VEC2:  state_r <= S_VEC2W;
        S_VEC2W: begin
          if (c_done) begin
            state_r <= S_ERR;
          end
        end
        S_ERR:   state_r <= S_ADE;
        S_ADE:   state_r <= S_ALIGN;
        S_ALIGN: state_r <= (zabs < HALF_PI_Q30) ? S_ROTW : S_PD0;
        S_ROTW: begin
          if (c_done) begin
            state_r <= S_PD0;
          end
        end
        S_PD0: state_r <= S_PD1;
        S_PD1: state_r <= S_PD2;
        S_PD2: state_r <= S_PD3;
        S_PD3: state_r <= S_PD4;
        S_PD4: state_r <= S_PD5;
        S_PD5: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            prev_dist_r <= dist_r;
            prev_ang_r  <= ae_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        tx_r <= in_bus.target_x;
        ty_r <= in_bus.target_y;
        rx_r <= in_bus.robot_x;
        ry_r <= in_bus.robot_y;
        qw_r <= in_bus.quat_w;
        qx_r <= in_bus.quat_x;
        qy_r <= in_bus.quat_y;
        qz_r <= in_bus.quat_z;
      end
      S_DIFF: begin
        dx_r <= 33'(tx_r) - 33'(rx_r);
        dy_r <= 33'(ty_r) - 33'(ry_r);
      end
      S_VEC1: begin
        desired_r <= '0;
        dist_r    <= '0;
      end
      S_VEC1W: begin
        if (c_done) begin
          desired_r <= c_z;
          xs_r      <= xg_rnd[CW-1:16];
        end
      end
      S_DIST: begin
        dist_r <= (mag_sum[MPW-1:56] != '0) ? 32'hFFFF_FFFF : mag_sum[55:24];
      end
      S_GOAL: begin
        if (out_load) begin
          out_lin_r  <= '0;
          out_ang_r  <= '0;
          out_goal_r <= 1'b1;
        end
      end
      S_Q1: acc_r  <= 50'(mul_p);
      S_Q2: sum1_r <= 33'(acc_r + mul_p);
      S_Q3: acc_r  <= 50'(mul_p);
      S_Q4: sum2_r <= 33'(acc_r + mul_p);
      S_VEC2W: begin
        if (c_done) begin
          yaw_r <= c_z;
        end
      end
      S_ERR: ae_r  <= 16'(ae_full);
      S_ADE: ade_r <= 16'(dd2);
      S_ALIGN: align_r <= '0;
      S_ROTW: begin
        if (c_done) begin
          align_r <= (al_full < 0) ? 16'd0 :
                     (al_full > CW'(32768)) ? 16'h8000 : al_full[15:0];
        end
      end
      S_PD1: acc_r <= 50'(mul_p);
      S_PD2: begin
        vpd_r <= 51'(acc_r + mul_p);
        acc_r <= '0;
      end
      S_PD3: acc_r <= 50'(mul_p);
      S_PD4: begin
        wq_r <= (w_rnd > max_ang_s) ? 16'(max_ang_s) :
                (w_rnd < -max_ang_s) ? 16'(-max_ang_s) : 16'(w_rnd);
      end
      S_PD5: begin
        if (out_load) begin
          out_lin_r  <= v_fin;
          out_ang_r  <= wq_r;
          out_goal_r <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign in_bus.ready         = (state_r == S_IDLE);
  assign out_bus.valid        = out_valid_r;
  assign out_bus.linear_vel   = out_lin_r;
  assign out_bus.angular_vel  = out_ang_r;
  assign out_bus.goal_reached = out_goal_r;

endmodule

>>> sim/pdfv_checker.sv
// checker for the pd follow velocity controller: predicts each velocity command and compares
`timescale 1ns / 100ps
module pdfv_checker import pdfv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pdfv_in_if.sink     in_mon,
  pdfv_out_if.sink    out_mon,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [30:0] cfg_data,
  output int          err_cnt,
  output int          pending
);

  typedef struct packed {
    logic [14:0]        lin;
    logic signed [15:0] ang;
    logic               goal;
  } vel_cmd_t;

  localparam longint P30  = 64'sd3373259426;
  localparam longint TP30 = 64'sd6746518852;
  localparam longint HP30 = 64'sd1686629713;
  localparam longint IG30 = 64'sd652032874;
  localparam longint IG24 = 64'sd10188014;
  localparam longint P13  = 64'sd25736;
  localparam longint TP13 = 64'sd51472;

  vel_cmd_t cmd_q[$];
  longint g_kpl, g_kdl, g_kpa, g_kda, g_tol, g_vmax, g_wmax;
  longint last_dist, last_ang;

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint arc_step(int i);
    longint tb[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                       33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
    if (i <= 10) return tb[i];
    return (64'sd1 << 30) >>> i;
  endfunction

  function automatic longint vec_angle(longint x, longint y, output longint xo);
    longint z, xs, ys;
    z = 0;
    x = x * 65536;
    y = y * 65536;
    if (x < 0) begin
      z = (y >= 0) ? P30 : -P30;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_ITERATIONS_DEF; i++) begin
      xs = sra(x, i);
      ys = sra(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += arc_step(i);
      end else begin
        x -= ys; y += xs; z -= arc_step(i);
      end
    end
    xo = x;
    return z;
  endfunction

  function automatic longint cos_q30(longint z);
    longint x, y, xs, ys;
    x = IG30;
    y = 0;
    for (int i = 0; i < CORDIC_ITERATIONS_DEF; i++) begin
      xs = sra(x, i);
      ys = sra(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= arc_step(i);
      end else begin
        x += ys; y -= xs; z += arc_step(i);
      end
    end
    return x;
  endfunction

  task automatic predict_velocity(input logic signed [31:0] tx, ty, rx, ry,
                                  input logic signed [15:0] qw, qx, qy, qz);
    longint dx, dy, xg, head, yaw, e30, ae, ade, align, za, d, vpd, v, w, wq;
    longint unsigned xs, mag, dist_q;
    vel_cmd_t c;
    dx = longint'(tx) - longint'(rx);
    dy = longint'(ty) - longint'(ry);
    if (dx == 0 && dy == 0) begin
      head = 0;
      mag = 0;
    end else begin
      head = vec_angle(dx, dy, xg);
      xs = (longint'(xg) + 32768) >> 16;
      mag = (xs * IG24 + (64'd1 << 23)) >> 24;
    end
    dist_q = mag > 64'hFFFFFFFF ? 64'hFFFFFFFF : mag;
    if (dist_q < g_tol) begin
      c = '{lin: '0, ang: '0, goal: 1'b1};
      last_dist = 0;
      last_ang = 0;
    end else begin
      yaw = vec_angle(2 * (longint'(qw) * qz + longint'(qx) * qy),
                      (64'sd1 << 28) - 2 * (longint'(qy) * qy + longint'(qz) * qz), xg);
      e30 = head - yaw;
      if (e30 > P30) e30 -= TP30;
      if (e30 < -P30) e30 += TP30;
      ae = sra(e30 + 65536, 17);
      ade = ae - last_ang;
      if (ade > P13) ade -= TP13;
      if (ade < -P13) ade += TP13;
      za = ae * 131072;
      if (za < 0) za = -za;
      if (za >= HP30) align = 0;
      else begin
        align = sra(cos_q30(ae * 131072) + 16384, 15);
        if (align < 0) align = 0;
        if (align > 32768) align = 32768;
      end
      d = longint'(dist_q) - last_dist;
      vpd = g_kpl * longint'(dist_q) + g_kdl * d;
      if (vpd <= 0) v = 0;
      else begin
        if (vpd > (64'sd1 << 43)) vpd = 64'sd1 << 43;
        v = (vpd * align + (64'sd1 << 26)) >>> 27;
        if (v > g_vmax) v = g_vmax;
      end
      w = g_kpa * ae + g_kda * ade;
      wq = sra(w + 256, 9);
      if (wq > g_wmax) wq = g_wmax;
      if (wq < -g_wmax) wq = -g_wmax;
      c = '{lin: v[14:0], ang: wq[15:0], goal: 1'b0};
      last_dist = longint'(dist_q);
      last_ang = ae;
    end
    cmd_q.push_back(c);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_cnt++;
  endtask

  assign pending = cmd_q.size();

  initial err_cnt = 0;

  always @(posedge clk) begin
    vel_cmd_t e;
    if (!rst_n) begin
      g_kpl = 256; g_kdl = 2560; g_kpa = 640; g_kda = 3840;
      g_tol = 9830; g_vmax = 4096; g_wmax = 8192;
      last_dist = 0;
      last_ang = 0;
      cmd_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_KP_LIN:      g_kpl = longint'(cfg_data[15:0]);
          REG_KD_LIN:      g_kdl = longint'(cfg_data[15:0]);
          REG_KP_ANG:      g_kpa = longint'(cfg_data[15:0]);
          REG_KD_ANG:      g_kda = longint'(cfg_data[15:0]);
          REG_GOAL_TOL:    g_tol = longint'(cfg_data);
          REG_MAX_LIN_VEL: g_vmax = longint'(cfg_data[14:0]);
          REG_MAX_ANG_VEL: g_wmax = longint'(cfg_data[14:0]);
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (cmd_q.size() == 0) report_mismatch("unexpected beat", 1, 0);
        else begin
          e = cmd_q.pop_front();
          if (out_mon.linear_vel !== e.lin)
            report_mismatch("linear_vel", out_mon.linear_vel, e.lin);
          if (out_mon.angular_vel !== e.ang)
            report_mismatch("angular_vel", out_mon.angular_vel, e.ang);
          if (out_mon.goal_reached !== e.goal)
            report_mismatch("goal_reached", out_mon.goal_reached, e.goal);
        end
      end
      if (in_mon.valid && in_mon.ready && in_mon.poses_ready)
        predict_velocity(in_mon.target_x, in_mon.target_y, in_mon.robot_x, in_mon.robot_y,
                         in_mon.quat_w, in_mon.quat_x, in_mon.quat_y, in_mon.quat_z);
    end
  end

endmodule

>>> sim/tb_pd_follow_velocity_controller_unit.sv
// top of the testbench: clock, reset, pose stimulus, register writes and verdict
`timescale 1ns / 100ps
module tb_pd_follow_velocity_controller_unit import pdfv_pkg::*;;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [30:0] cfg_data = '0;
  logic        sink_calm = 1'b0;
  int          err_cnt;
  int          pending;

  pdfv_in_if  in_bus();
  pdfv_out_if out_bus();

  pd_follow_velocity_controller_unit u_dut (
    .clk, .rst_n, .in_bus(in_bus.sink), .out_bus(out_bus.source),
    .cfg_we, .cfg_idx, .cfg_data
  );

  pdfv_checker u_chk (
    .clk, .rst_n, .in_mon(in_bus.sink), .out_mon(out_bus.sink),
    .cfg_we, .cfg_idx, .cfg_data, .err_cnt, .pending
  );

  always #4 clk = ~clk;

  initial begin
    in_bus.valid = 1'b0;
    in_bus.poses_ready = 1'b0;
    in_bus.target_x = '0;
    in_bus.target_y = '0;
    in_bus.robot_x = '0;
    in_bus.robot_y = '0;
    in_bus.quat_w = '0;
    in_bus.quat_x = '0;
    in_bus.quat_y = '0;
    in_bus.quat_z = '0;
    out_bus.ready = 1'b0;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    int hold;
    if (sink_calm || $urandom_range(0, 3) != 0) out_bus.ready <= 1'b1;
    else begin
      hold = $urandom_range(1, 4);
      out_bus.ready <= 1'b0;
      repeat (hold) @(posedge clk);
      out_bus.ready <= 1'b1;
    end
  end

  function automatic logic signed [31:0] rand_pos(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
      2: return $signed($urandom_range(0, 4000)) - 2000;
      default: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_quat();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
  endfunction

  task automatic send_pose(input logic pr, input logic signed [31:0] tx, ty, rx, ry,
                           input logic signed [15:0] qw, qx, qy, qz, input bit gaps);
    if (gaps && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.poses_ready <= pr;
    in_bus.target_x <= tx;
    in_bus.target_y <= ty;
    in_bus.robot_x <= rx;
    in_bus.robot_y <= ry;
    in_bus.quat_w <= qw;
    in_bus.quat_x <= qx;
    in_bus.quat_y <= qy;
    in_bus.quat_z <= qz;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic rand_pose(input bit gaps);
    int m;
    m = $urandom_range(0, 3);
    send_pose($urandom_range(0, 9) != 0, rand_pos(m), rand_pos(m), rand_pos(m), rand_pos(m),
              rand_quat(), rand_quat(), rand_quat(), rand_quat(), gaps);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_gains(input logic [15:0] a, b, c, d, input logic [30:0] tol,
                           input logic [14:0] vm, wm);
    write_reg(REG_KP_LIN, 31'(a));
    write_reg(REG_KD_LIN, 31'(b));
    write_reg(REG_KP_ANG, 31'(c));
    write_reg(REG_KD_ANG, 31'(d));
    write_reg(REG_GOAL_TOL, tol);
    write_reg(REG_MAX_LIN_VEL, 31'(vm));
    write_reg(REG_MAX_ANG_VEL, 31'(wm));
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed beats
    send_pose(1'b0, 32'sd100000, 0, 0, 0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_pose(1'b1, 0, 0, 0, 0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_pose(1'b1, 32'sd65536, 0, 0, 0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_pose(1'b1, 32'sd65536, 0, 0, 0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_pose(1'b1, -32'sd65536, 0, 0, 0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_pose(1'b1, -32'sd65536, -32'sd10, 0, 0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0);
    send_pose(1'b1, 0, 32'sd200000, 0, 0, 16'sd16384, 16'sd0, 16'sd0, -16'sd16384, 1'b0);
    send_pose(1'b1, 0, -32'sd200000, 0, 0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 1'b0);
    send_pose(1'b1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
              16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 1'b0);
    send_pose(1'b1, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
              -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 1'b0);
    send_pose(1'b1, 32'sd5000, 0, 0, 0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_pose(1'b1, 32'sd300000, 32'sd1, 0, 0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
              1'b0);
    send_pose(1'b1, 32'sd40000, 32'sd40000, 0, 0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b0);
    drain();
    set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 31'h7FFFFFFF, 15'h7FFF, 15'h7FFF);
    send_pose(1'b1, 32'sd100000, 0, 0, 0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_pose(1'b1, 32'sh7FFFFFFF, 0, 32'sh80000000, 0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
              1'b0);
    drain();
    set_gains(16'd0, 16'd0, 16'd0, 16'd0, 31'd0, 15'd0, 15'd0);
    send_pose(1'b1, 0, 0, 0, 0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_pose(1'b1, 32'sd65536, 32'sd65536, 0, 0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    drain();
    set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 31'd0, 15'h7FFF, 15'h7FFF);
    for (int i = 0; i < 400; i++) rand_pose(1'b1);
    drain();
    for (int p = 0; p < 3; p++) begin
      set_gains(16'($urandom_range(0, 2048)), 16'($urandom), 16'($urandom_range(0, 4096)),
                16'($urandom), 31'($urandom_range(0, 200000)), 15'($urandom), 15'($urandom));
      for (int i = 0; i < 400; i++) rand_pose(1'b1);
      drain();
    end
    set_gains(16'd256, 16'd2560, 16'd640, 16'd3840, 31'd9830, 15'd4096, 15'd8192);
    sink_calm <= 1'b1;
    for (int i = 0; i < 400; i++) rand_pose(1'b0);
    drain();
    if (err_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> pd_follow_velocity_controller_unit.f
rtl/pdfv_pkg.sv
rtl/pdfv_ifs.sv
rtl/pdfv_cordic.sv
rtl/pdfv_mul.sv
rtl/pd_follow_velocity_controller_unit.sv
sim/pdfv_checker.sv
sim/tb_pd_follow_velocity_controller_unit.sv
